### design/ilb_pkg.sv
// ---------------------------------------------------------------------------
// ilb_pkg: shared types and codes for the indexed list buffer
// Field widths, operation and status codes, datapath selector codes and the
// command and flag bundles that pass between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ilb_pkg;

	// fixed field widths of the request and result words
	localparam int OP_W     = 3;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 3;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	// operation codes
	localparam op_t OP_READ       = 3'd0;
	localparam op_t OP_APPEND     = 3'd1;
	localparam op_t OP_INSERT     = 3'd2;
	localparam op_t OP_REMOVE_AT  = 3'd3;
	localparam op_t OP_REMOVE_VAL = 3'd4;

	// status codes
	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_RANGE   = 3'd1;
	localparam status_t ST_EMPTY   = 3'd2;
	localparam status_t ST_FULL    = 3'd3;
	localparam status_t ST_MISSING = 3'd4;

	// read address select
	localparam logic [1:0] RD_POS    = 2'd0;
	localparam logic [1:0] RD_IDX    = 2'd1;
	localparam logic [1:0] RD_IDX_M1 = 2'd2;
	localparam logic [1:0] RD_IDX_P1 = 2'd3;

	// write address select
	localparam logic WA_COUNT = 1'b0;
	localparam logic WA_IDX   = 1'b1;

	// write data / result source select
	localparam logic SRC_VAL   = 1'b0;
	localparam logic SRC_RDATA = 1'b1;

	// index load source
	localparam logic [1:0] IDX_FROM_ZERO  = 2'd0;
	localparam logic [1:0] IDX_FROM_POS   = 2'd1;
	localparam logic [1:0] IDX_FROM_COUNT = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_en;
		logic       wr_addr_sel;
		logic       wr_data_sel;
		logic       idx_ld;
		logic [1:0] idx_src;
		logic       idx_inc;
		logic       idx_dec;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_cap;
		logic       res_src;
		logic       st_wr;
		status_t    st_code;
		logic       out_load;
	} ilb_cmd_t;

	// datapath to controller status
	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic pos_ge_cnt;
		logic pos_gt_cnt;
		logic idx_eq_pos;
		logic idx_last;
		logic match;
		logic out_busy;
	} ilb_flags_t;

endpackage

`default_nettype wire

### design/ilb_ram.sv
// ---------------------------------------------------------------------------
// ilb_ram: generic single-write, single-read RAM
// One write port and one read port per cycle; read data is registered and
// holds until the next read.
// ---------------------------------------------------------------------------
`default_nettype none

module ilb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/ilb_controller.sv
// ---------------------------------------------------------------------------
// ilb_controller: request sequencer for the indexed list buffer
// Checks each request, then steps the datapath through reads, shifts and
// scans one memory access at a time, and hands the result word out.
// ---------------------------------------------------------------------------
`default_nettype none

module ilb_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire ilb_pkg::ilb_flags_t flags,
	output ilb_pkg::ilb_cmd_t        cmd
);

	import ilb_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_GET    = 4'd2;
	localparam logic [3:0] S_UP_CHK = 4'd3;
	localparam logic [3:0] S_UP_WR  = 4'd4;
	localparam logic [3:0] S_DN_GET = 4'd5;
	localparam logic [3:0] S_DN_CHK = 4'd6;
	localparam logic [3:0] S_DN_WR  = 4'd7;
	localparam logic [3:0] S_SC_RD  = 4'd8;
	localparam logic [3:0] S_SC_CMP = 4'd9;
	localparam logic [3:0] S_FINISH = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// new word only taken when idle
	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_FINISH;
				unique case (flags.op)
					OP_READ: begin
						priority if (flags.empty) begin
							cmd.st_wr   = 1'b1;
							cmd.st_code = ST_EMPTY;
						end else if (flags.pos_ge_cnt) begin
							cmd.st_wr   = 1'b1;
							cmd.st_code = ST_RANGE;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = S_GET;
						end
					end
					OP_APPEND: begin
						priority if (flags.full) begin
							cmd.st_wr   = 1'b1;
							cmd.st_code = ST_FULL;
						end else begin
							cmd.wr_en       = 1'b1;
							cmd.wr_addr_sel = WA_COUNT;
							cmd.wr_data_sel = SRC_VAL;
							cmd.res_cap     = 1'b1;
							cmd.res_src     = SRC_VAL;
							cmd.cnt_inc     = 1'b1;
						end
					end
					OP_INSERT: begin
						priority if (flags.full) begin
							cmd.st_wr   = 1'b1;
							cmd.st_code = ST_FULL;
						end else if (flags.pos_gt_cnt) begin
							cmd.st_wr   = 1'b1;
							cmd.st_code = ST_RANGE;
						end else begin
							cmd.idx_ld  = 1'b1;
							cmd.idx_src = IDX_FROM_COUNT;
							state_d     = S_UP_CHK;
						end
					end
					OP_REMOVE_AT: begin
						priority if (flags.empty) begin
							cmd.st_wr   = 1'b1;
							cmd.st_code = ST_EMPTY;
						end else if (flags.pos_ge_cnt) begin
							cmd.st_wr   = 1'b1;
							cmd.st_code = ST_RANGE;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.rd_sel  = RD_POS;
							cmd.idx_ld  = 1'b1;
							cmd.idx_src = IDX_FROM_POS;
							state_d     = S_DN_GET;
						end
					end
					OP_REMOVE_VAL: begin
						priority if (flags.empty) begin
							cmd.st_wr   = 1'b1;
							cmd.st_code = ST_EMPTY;
						end else begin
							cmd.idx_ld  = 1'b1;
							cmd.idx_src = IDX_FROM_ZERO;
							state_d     = S_SC_RD;
						end
					end
					// unused op codes: no change, ok status, zero value
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_GET: begin
				cmd.res_cap = 1'b1;
				cmd.res_src = SRC_RDATA;
				state_d     = S_FINISH;
			end
			// insert: move entries up from the tail, then drop the word in
			S_UP_CHK: begin
				if (flags.idx_eq_pos) begin
					cmd.wr_en       = 1'b1;
					cmd.wr_addr_sel = WA_IDX;
					cmd.wr_data_sel = SRC_VAL;
					cmd.res_cap     = 1'b1;
					cmd.res_src     = SRC_VAL;
					cmd.cnt_inc     = 1'b1;
					state_d         = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_M1;
					state_d    = S_UP_WR;
				end
			end
			S_UP_WR: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_addr_sel = WA_IDX;
				cmd.wr_data_sel = SRC_RDATA;
				cmd.idx_dec     = 1'b1;
				state_d         = S_UP_CHK;
			end
			S_DN_GET: begin
				cmd.res_cap = 1'b1;
				cmd.res_src = SRC_RDATA;
				state_d     = S_DN_CHK;
			end
			// removal: close the gap at idx by moving later entries down
			S_DN_CHK: begin
				if (flags.idx_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_P1;
					state_d    = S_DN_WR;
				end
			end
			S_DN_WR: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_addr_sel = WA_IDX;
				cmd.wr_data_sel = SRC_RDATA;
				cmd.idx_inc     = 1'b1;
				state_d         = S_DN_CHK;
			end
			// value search: read, then compare, each entry from the head
			S_SC_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d    = S_SC_CMP;
			end
			S_SC_CMP: begin
				priority if (flags.match) begin
					cmd.res_cap = 1'b1;
					cmd.res_src = SRC_RDATA;
					state_d     = S_DN_CHK;
				end else if (flags.idx_last) begin
					cmd.st_wr   = 1'b1;
					cmd.st_code = ST_MISSING;
					state_d     = S_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SC_RD;
				end
			end
			S_FINISH: begin
				if (!flags.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### design/ilb_datapath.sv
// ---------------------------------------------------------------------------
// ilb_datapath: entry store, count, index and result registers
// Holds the latched request, the entry memory, the walking index used for
// shifts and scans, and the output register of the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ilb_datapath #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ilb_pkg::ilb_cmd_t            cmd,
	output ilb_pkg::ilb_flags_t               flags,
	input  wire logic [ilb_pkg::OP_W-1:0]     op,
	input  wire logic [ilb_pkg::POS_W-1:0]    position,
	input  wire logic [ilb_pkg::VALUE_W-1:0]  value_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [ilb_pkg::VALUE_W-1:0]  value_out,
	output logic      [ilb_pkg::COUNT_W-1:0]  entry_count,
	output logic      [ilb_pkg::STATUS_W-1:0] status
);

	import ilb_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

	// latched request
	op_t                   op_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic [DATA_WIDTH-1:0] res_q;
	status_t               status_q;

	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic [COUNT_W-1:0]    out_count_q;
	status_t               out_status_q;

	logic [CMP_W-1:0]      pos_x;
	logic [CMP_W-1:0]      cnt_x;
	logic [CMP_W-1:0]      idx_x;
	logic [CW-1:0]         idx_m1;
	logic [CW-1:0]         idx_p1;
	logic [CW:0]           idx_next;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;

	// compare operands at a common width
	assign pos_x    = CMP_W'(pos_q);
	assign cnt_x    = CMP_W'(count_q);
	assign idx_x    = CMP_W'(idx_q);
	assign idx_m1   = idx_q - CW'(1);
	assign idx_p1   = idx_q + CW'(1);
	assign idx_next = {1'b0, idx_q} + (CW + 1)'(1);

	// status toward the controller
	always_comb begin
		flags            = '0;
		flags.op         = op_q;
		flags.empty      = (count_q == '0);
		flags.full       = (count_q == CW'(CAPACITY));
		flags.pos_ge_cnt = (pos_x >= cnt_x);
		flags.pos_gt_cnt = (pos_x > cnt_x);
		flags.idx_eq_pos = (idx_x == pos_x);
		flags.idx_last   = (idx_next >= {1'b0, count_q});
		flags.match      = (rd_data == val_q);
		flags.out_busy   = out_valid_q && out_stall;
	end

	// memory address and data selection
	always_comb begin
		unique case (cmd.rd_sel)
			RD_POS:    rd_addr = AW'(pos_q);
			RD_IDX:    rd_addr = idx_q[AW-1:0];
			RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
			RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
			default:   rd_addr = idx_q[AW-1:0];
		endcase
	end

	assign wr_en   = cmd.wr_en;
	assign wr_addr = (cmd.wr_addr_sel == WA_IDX) ? idx_q[AW-1:0] : count_q[AW-1:0];
	assign wr_data = (cmd.wr_data_sel == SRC_RDATA) ? rd_data : val_q;

	ilb_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_ilb_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			pos_q <= position;
			val_q <= DATA_WIDTH'(value_in);
		end
	end

	// result value and status
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q <= '0;
		end else if (cmd.res_cap) begin
			res_q <= (cmd.res_src == SRC_RDATA) ? rd_data : val_q;
		end
		if (cmd.load) begin
			status_q <= ST_OK;
		end else if (cmd.st_wr) begin
			status_q <= cmd.st_code;
		end
	end

	// entry count and walking index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			priority if (cmd.idx_ld) begin
				unique case (cmd.idx_src)
					IDX_FROM_POS:   idx_q <= CW'(pos_q);
					IDX_FROM_COUNT: idx_q <= count_q;
					default:        idx_q <= '0;
				endcase
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_m1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q  <= VALUE_W'(res_q);
			out_count_q  <= COUNT_W'(count_q);
			out_status_q <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign value_out   = out_value_q;
	assign entry_count = out_count_q;
	assign status      = out_status_q;

endmodule

`default_nettype wire

### design/indexed_list_buffer_unit.sv
// ---------------------------------------------------------------------------
// indexed_list_buffer_unit: ordered list of up to CAPACITY words
// Each request word (op, position, value_in) on the input channel gives one
// result word (value_out, entry_count, status) on the output channel. Both
// channels move a word at an edge where valid is high and stall is low.
// Entries live in one RAM with a registered read port, and work goes one
// request at a time, one memory access at a time. Reads, appends, errors
// and unknown ops move no entries; insert and remove shift entries through
// the single RAM port in a read/write loop, and remove by value first scans
// from the head for a match.
// A new request is taken as soon as the previous one is in the output
// register, even while the receiver stalls it; the sequencer then waits
// at the end of its work until the output register is free.
// Reset empties the list (count zero) and clears the result valid flag; the
// entry RAM is not cleared, as entries above the count are never read.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_list_buffer_unit #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [ilb_pkg::OP_W-1:0]     op,
	input  wire logic [ilb_pkg::POS_W-1:0]    position,
	input  wire logic [ilb_pkg::VALUE_W-1:0]  value_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [ilb_pkg::VALUE_W-1:0]  value_out,
	output logic      [ilb_pkg::COUNT_W-1:0]  entry_count,
	output logic      [ilb_pkg::STATUS_W-1:0] status
);

	import ilb_pkg::*;

	ilb_cmd_t   cmd;
	ilb_flags_t flags;

	// sequencer
	ilb_controller u_ilb_controller (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.flags    (flags),
		.cmd      (cmd)
	);

	// store and registers
	ilb_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ilb_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.flags       (flags),
		.op          (op),
		.position    (position),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value_out   (value_out),
		.entry_count (entry_count),
		.status      (status)
	);

endmodule

`default_nettype wire

### design/ilb_checker.sv
// ---------------------------------------------------------------------------
// ilb_checker: port-level checks for the indexed list buffer
// Watches the result channel for held words and consistent status codes.
// ---------------------------------------------------------------------------
`default_nettype none

module ilb_checker #(
	parameter int CAPACITY = 64
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [ilb_pkg::VALUE_W-1:0]  value_out,
	input wire logic [ilb_pkg::COUNT_W-1:0]  entry_count,
	input wire logic [ilb_pkg::STATUS_W-1:0] status
);

	import ilb_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_out)
			&& $stable(entry_count) && $stable(status))
		else $error("result word changed while stalled");

	// failed request carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (value_out == '0))
		else $error("nonzero value with error status");

	// empty status only with an empty list
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (entry_count == '0))
		else $error("empty status with entries held");

	// full status only with a full list
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |->
			(entry_count == COUNT_W'(CAPACITY)))
		else $error("full status below capacity");

endmodule

bind indexed_list_buffer_unit ilb_checker #(
	.CAPACITY (CAPACITY)
) u_ilb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.value_out   (value_out),
	.entry_count (entry_count),
	.status      (status)
);

`default_nettype wire

### tb/list_checker.sv
// ---------------------------------------------------------------------------
// list_checker: result checker for the indexed list buffer
// Watches both channels of the list unit. Every accepted request word
// updates a shadow list and queues the result word it should produce.
// Every accepted result word is compared field by field with the oldest
// queued result. The mismatch count and the number of results still due go
// back to the testbench top.
// ---------------------------------------------------------------------------
`default_nettype none

module list_checker #(
	parameter int DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_stall,
	input  wire logic [ilb_pkg::OP_W-1:0]     op,
	input  wire logic [ilb_pkg::POS_W-1:0]    position,
	input  wire logic [ilb_pkg::VALUE_W-1:0]  value_in,
	input  wire logic                         out_valid,
	input  wire logic                         out_stall,
	input  wire logic [ilb_pkg::VALUE_W-1:0]  value_out,
	input  wire logic [ilb_pkg::COUNT_W-1:0]  entry_count,
	input  wire logic [ilb_pkg::STATUS_W-1:0] status,
	output int                                mismatches,
	output int                                awaiting
);

	import ilb_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		status_t            st;
	} list_reply_t;

	// shadow copy of the list contents and fill level
	logic [VALUE_W-1:0] shadow_list [DEPTH];
	int                 shadow_count = 0;
	list_reply_t        replies_due [$];
	list_reply_t        oldest;

	initial begin
		mismatches = 0;
		awaiting   = 0;
	end

	// drop entry at idx, later entries move down one place
	function automatic void close_gap(int idx);
		int i;
		for (i = idx; i + 1 < shadow_count; i++)
			shadow_list[i] = shadow_list[i + 1];
		shadow_count--;
	endfunction

	// apply one request to the shadow list, return the result word it yields
	function automatic list_reply_t apply_list_request(op_t o, logic [POS_W-1:0] p,
			logic [VALUE_W-1:0] v);
		list_reply_t r;
		int          i;
		int          hit;
		r    = '0;
		r.st = ST_OK;
		hit  = -1;
		case (o)
			OP_READ: begin
				if (shadow_count == 0)
					r.st = ST_EMPTY;
				else if (int'(p) >= shadow_count)
					r.st = ST_RANGE;
				else
					r.value = shadow_list[p];
			end
			OP_APPEND: begin
				if (shadow_count >= DEPTH)
					r.st = ST_FULL;
				else begin
					shadow_list[shadow_count] = v;
					shadow_count++;
					r.value = v;
				end
			end
			OP_INSERT: begin
				if (shadow_count >= DEPTH)
					r.st = ST_FULL;
				else if (int'(p) > shadow_count)
					r.st = ST_RANGE;
				else begin
					for (i = shadow_count; i > int'(p); i--)
						shadow_list[i] = shadow_list[i - 1];
					shadow_list[p] = v;
					shadow_count++;
					r.value = v;
				end
			end
			OP_REMOVE_AT: begin
				if (shadow_count == 0)
					r.st = ST_EMPTY;
				else if (int'(p) >= shadow_count)
					r.st = ST_RANGE;
				else begin
					r.value = shadow_list[p];
					close_gap(int'(p));
				end
			end
			OP_REMOVE_VAL: begin
				if (shadow_count == 0)
					r.st = ST_EMPTY;
				else begin
					// first match wins
					for (i = 0; i < shadow_count; i++)
						if (hit < 0 && shadow_list[i] == v)
							hit = i;
					if (hit < 0)
						r.st = ST_MISSING;
					else begin
						r.value = shadow_list[hit];
						close_gap(hit);
					end
				end
			end
			default: ;  // spare op codes: no change, ok status
		endcase
		r.count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	// compare results first, then queue the prediction for a new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_count = 0;
			replies_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("result word with none due: value_out %h entry_count %0d status %0d",
						value_out, entry_count, status);
					mismatches++;
				end else begin
					oldest = replies_due.pop_front();
					if (value_out !== oldest.value) begin
						$error("value_out mismatch: expected %h, actual %h",
							oldest.value, value_out);
						mismatches++;
					end
					if (entry_count !== oldest.count) begin
						$error("entry_count mismatch: expected %0d, actual %0d",
							oldest.count, entry_count);
						mismatches++;
					end
					if (status !== oldest.st) begin
						$error("status mismatch: expected %0d, actual %0d",
							oldest.st, status);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(apply_list_request(op, position, value_in));
		end
		awaiting = replies_due.size();
	end

endmodule

`default_nettype wire

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for indexed_list_buffer_unit
// A directed run over empty, error and spare-op cases, then random words in
// fill, drain and mixed phases so the list swings between empty and full.
// Both sides idle at random; the receiver holds off once for a long stretch
// and the sender drains the block at each phase change. Checking is done by
// list_checker.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

	import ilb_pkg::*;

	localparam int LIST_DEPTH     = 64;
	localparam int CLK_PERIOD     = 10;
	localparam int IDLE_PCT       = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 150;
	localparam int RANDOM_WORDS   = 850;
	localparam int PHASE_WORDS    = 110;
	localparam int HOLD_AT_WORD   = 200;
	localparam int QUIET_FROM     = 450;
	localparam int QUIET_TO       = 600;
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int POOL_SIZE      = 8;

	localparam op_t OP_SPARE_FIRST = OP_REMOVE_VAL + op_t'(1);
	localparam op_t OP_SPARE_LAST  = '1;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} mix_phase_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     op          = '0;
	logic [POS_W-1:0]    position    = '0;
	logic [VALUE_W-1:0]  value_in    = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [VALUE_W-1:0]  value_out;
	logic [COUNT_W-1:0]  entry_count;
	logic [STATUS_W-1:0] status;

	int   mismatches;
	int   awaiting;

	// sender-owned controls for the receiver
	logic quiet_run  = 1'b0;
	logic hold_go    = 1'b0;
	int   hold_left  = 0;
	bit   hold_taken = 1'b0;

	logic [VALUE_W-1:0] value_pool [POOL_SIZE];

	indexed_list_buffer_unit #(
		.CAPACITY   (LIST_DEPTH),
		.DATA_WIDTH (VALUE_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.position    (position),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value_out   (value_out),
		.entry_count (entry_count),
		.status      (status)
	);

	list_checker #(
		.DEPTH (LIST_DEPTH)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.position    (position),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value_out   (value_out),
		.entry_count (entry_count),
		.status      (status),
		.mismatches  (mismatches),
		.awaiting    (awaiting)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// hard stop
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("status: fail");
		$finish;
	end

	// receiver: random stalls, one long hold-off once the sender asks
	always @(posedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= !quiet_run && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// offer one word, return just after the edge that takes it
	task automatic offer_word(input op_t o, input logic [POS_W-1:0] p,
			input logic [VALUE_W-1:0] v);
		while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		position <= p;
		value_in <= v;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
	endtask

	// stop sending until every due result has come back
	task automatic wait_all_answered();
		in_valid <= 1'b0;
		forever begin
			@(negedge clk);
			if (awaiting == 0)
				break;
		end
		@(posedge clk);
	endtask

	// mostly small positions so removes hit; some past the end and beyond 63
	function automatic logic [POS_W-1:0] pick_position();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return POS_W'($urandom_range(0, 3));
		else if (roll < 85)
			return POS_W'($urandom_range(0, LIST_DEPTH + 2));
		else
			return POS_W'($urandom);
	endfunction

	// pool values give remove-by-value hits and duplicates
	function automatic logic [VALUE_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 70)
			return value_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			return $urandom;
	endfunction

	// op mix depends on phase: fill pushes the list to full, drain empties it
	function automatic op_t pick_op(mix_phase_t ph);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			return op_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		case (ph)
			PH_FILL: begin
				if (roll < 68) return OP_APPEND;
				if (roll < 88) return OP_INSERT;
				if (roll < 94) return OP_READ;
				if (roll < 97) return OP_REMOVE_AT;
				return OP_REMOVE_VAL;
			end
			PH_DRAIN: begin
				if (roll < 8)  return OP_APPEND;
				if (roll < 13) return OP_INSERT;
				if (roll < 25) return OP_READ;
				if (roll < 65) return OP_REMOVE_AT;
				return OP_REMOVE_VAL;
			end
			default: begin
				if (roll < 28) return OP_APPEND;
				if (roll < 45) return OP_INSERT;
				if (roll < 62) return OP_READ;
				if (roll < 80) return OP_REMOVE_AT;
				return OP_REMOVE_VAL;
			end
		endcase
	endfunction

	initial begin
		int         n;
		op_t        spare;
		mix_phase_t ph;

		value_pool[0] = '0;
		value_pool[1] = '1;
		for (n = 2; n < POOL_SIZE; n++)
			value_pool[n] = $urandom;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list on every op that reads or removes
		offer_word(OP_READ, '0, '0);
		offer_word(OP_REMOVE_AT, '0, '0);
		offer_word(OP_REMOVE_VAL, '0, '0);
		// spare op codes are ignored
		spare = OP_SPARE_FIRST;
		forever begin
			offer_word(spare, '1, '1);
			if (spare == OP_SPARE_LAST)
				break;
			spare++;
		end
		// build a short list with the value extremes
		offer_word(OP_APPEND, '0, '0);
		offer_word(OP_APPEND, '0, '1);
		offer_word(OP_INSERT, '0, 32'h5a5a_5a5a);
		offer_word(OP_INSERT, POS_W'(3), 32'ha5a5_a5a5);  // position at count appends
		offer_word(OP_INSERT, POS_W'(5), 32'h1111_1111);  // past the count
		offer_word(OP_INSERT, '1, 32'h2222_2222);
		// reads in and out of range
		offer_word(OP_READ, POS_W'(3), '0);
		offer_word(OP_READ, POS_W'(4), '0);
		offer_word(OP_READ, '1, '0);
		// remove by value: miss, then a hit in the middle
		offer_word(OP_REMOVE_VAL, '0, 32'h1234_5678);
		offer_word(OP_REMOVE_VAL, '0, '1);
		// remove at the last entry, out of range, then the head
		offer_word(OP_REMOVE_AT, POS_W'(2), '0);
		offer_word(OP_REMOVE_AT, POS_W'(5), '0);
		offer_word(OP_REMOVE_AT, '0, '0);
		offer_word(OP_REMOVE_VAL, '0, '0);
		wait_all_answered();

		// random phases
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n > 0 && n % PHASE_WORDS == 0)
				wait_all_answered();
			if (n == HOLD_AT_WORD)
				hold_go <= 1'b1;
			if (n == QUIET_FROM)
				quiet_run <= 1'b1;
			if (n == QUIET_TO)
				quiet_run <= 1'b0;
			ph = mix_phase_t'((n / PHASE_WORDS) % 3);
			offer_word(pick_op(ph), pick_position(), pick_value());
		end

		wait_all_answered();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
